### rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants for the isolated peak clipping filter.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int CFG_W       = 13;
  localparam int ROW_W       = 12;
  localparam int FRAME_H_MAX = 4096;
  localparam int RST_FRAME_W = 640;
  localparam int RST_FRAME_H = 480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  // which of the 4 neighbours lie inside the frame
  typedef struct packed {
    logic up;
    logic left;
    logic down;
    logic right;
  } nbr_en_t;

endpackage

### rtl/ipc_ram.sv
// ----------------------------------------------------------------------------
// ipc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ipc_clip.sv
// ----------------------------------------------------------------------------
// ipc_clip
// Clips a centre pixel to its largest in-frame neighbour when it is a
// strict local peak; otherwise passes it unchanged.
// ----------------------------------------------------------------------------
module ipc_clip import ipc_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic [PIXEL_BITS-1:0] centre,
  input  logic [PIXEL_BITS-1:0] up,
  input  logic [PIXEL_BITS-1:0] left,
  input  logic [PIXEL_BITS-1:0] down,
  input  logic [PIXEL_BITS-1:0] right,
  input  nbr_en_t               nbr_en,
  output logic [PIXEL_BITS-1:0] result
);

  logic [PIXEL_BITS-1:0] best;
  logic                  kept;

  always_comb begin
    best = '0;
    kept = 1'b0;
    if (nbr_en.up) begin
      if (up > best) best = up;
      if (up >= centre) kept = 1'b1;
    end
    if (nbr_en.left) begin
      if (left > best) best = left;
      if (left >= centre) kept = 1'b1;
    end
    if (nbr_en.down) begin
      if (down > best) best = down;
      if (down >= centre) kept = 1'b1;
    end
    if (nbr_en.right) begin
      if (right > best) best = right;
      if (right >= centre) kept = 1'b1;
    end
    // no neighbour at all (1x1 frame) falls through to zero
    result = kept ? centre : best;
  end

endmodule

### rtl/isolated_peak_clip_filter_core.sv
// Pipeline: the item that completes a window is registered in the s1 stage,
// its result in the output register; results trail the input by width+1 items.
// Throughput: one item per cycle unless the output stalls, set by the single
// line store read port and one write per item into the same store.
// Reset: frame size returns to 640x480, all positions and valids clear; line
// store contents are left as they are and are rewritten before use.
// ----------------------------------------------------------------------------
// isolated_peak_clip_filter_core
// Raster stream 4-neighbour isolated peak clipping with line stores.
// ----------------------------------------------------------------------------
module isolated_peak_clip_filter_core import ipc_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [PIXEL_BITS-1:0] in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_pixel_out,
  output logic                  out_end_of_frame,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int RST_W = (RST_FRAME_W > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_W;
  localparam logic [COL_W-1:0] W_M1_RST = COL_W'(RST_W - 1);
  localparam logic [ROW_W-1:0] H_M1_RST = ROW_W'(RST_FRAME_H - 1);

  // frame size, stored minus one
  logic [COL_W-1:0] w_m1_r, w_m1_nxt;
  logic [ROW_W-1:0] h_m1_r, h_m1_nxt;
  logic [31:0]      cfg_val;

  // input position runs up to the first column two rows past the frame while draining
  logic [COL_W-1:0] col_in_r, col_in_nxt;
  logic [ROW_W:0]   row_in_r, row_in_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic                  in_frame;
  logic                  acc;
  logic                  acc_active;
  logic [PIXEL_BITS-1:0] s0_pix;
  logic                  s0_emit;
  logic                  s0_eof;
  nbr_en_t               s0_nbr;

  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [COL_W-1:0]      s1_col_r;
  logic                  s1_emit_r;
  logic                  s1_eof_r;
  nbr_en_t               s1_nbr_r;
  logic                  s1_adv;
  logic                  s1_fire;

  logic [2*PIXEL_BITS-1:0] ram_rdata;
  logic [2*PIXEL_BITS-1:0] rd_pair;
  logic [2*PIXEL_BITS-1:0] wr_pair;
  logic                    byp_hit_r;
  logic [2*PIXEL_BITS-1:0] byp_data_r;
  logic [PIXEL_BITS-1:0]   a_cur;
  logic [PIXEL_BITS-1:0]   b_cur;

  // window history, advanced once per active item
  logic [PIXEL_BITS-1:0] a1_r, a2_r, b1_r, x1_r;
  logic [PIXEL_BITS-1:0] clip_pix;

  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_pix_r;
  logic                  out_eof_r;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_val  = 32'(cfg_wdata);
    w_m1_nxt = w_m1_r;
    h_m1_nxt = h_m1_r;
    if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          if (cfg_val == 32'd0) w_m1_nxt = '0;
          else if (cfg_val > 32'(MAX_WIDTH)) w_m1_nxt = COL_W'(MAX_WIDTH - 1);
          else w_m1_nxt = COL_W'(cfg_val - 32'd1);
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_val == 32'd0) h_m1_nxt = '0;
          else if (cfg_val > 32'(FRAME_H_MAX)) h_m1_nxt = ROW_W'(FRAME_H_MAX - 1);
          else h_m1_nxt = ROW_W'(cfg_val - 32'd1);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  assign s1_adv   = !s1_emit_r || !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  assign in_frame   = row_in_r <= {1'b0, h_m1_r};
  assign acc        = in_valid && in_ready;
  // a drain while the frame is still arriving is taken and dropped
  assign acc_active = acc && (!in_frame || (cmd_t'(in_command) == CMD_PIXEL));
  assign s0_pix     = in_frame ? in_pixel_in : '0;
  assign s0_emit    = (row_in_r >= (ROW_W+1)'(2)) ||
                      ((row_in_r == (ROW_W+1)'(1)) && (col_in_r != '0));
  assign s0_eof     = (out_row_r == h_m1_r) && (out_col_r == w_m1_r);

  always_comb begin
    s0_nbr.up    = out_row_r != '0;
    s0_nbr.left  = out_col_r != '0;
    s0_nbr.down  = out_row_r != h_m1_r;
    s0_nbr.right = out_col_r != w_m1_r;
  end

  always_comb begin
    col_in_nxt  = col_in_r;
    row_in_nxt  = row_in_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_wr_en) begin
      col_in_nxt  = '0;
      row_in_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (acc_active) begin
      if (col_in_r == w_m1_r) begin
        col_in_nxt = '0;
        row_in_nxt = row_in_r + (ROW_W+1)'(1);
      end else begin
        col_in_nxt = col_in_r + COL_W'(1);
      end
      if (s0_emit) begin
        if (s0_eof) begin
          col_in_nxt  = '0;
          row_in_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_r == w_m1_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  // ------------------------------------------------------------ line store
  // each column holds {centre row pixel, row above pixel}
  ipc_ram #(
    .WIDTH (2*PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (wr_pair),
    .rd_en   (acc_active),
    .rd_addr (col_in_r),
    .rd_data (ram_rdata)
  );

  // one-column frames read the column being written in the same cycle
  assign rd_pair = byp_hit_r ? byp_data_r : ram_rdata;
  assign a_cur   = rd_pair[2*PIXEL_BITS-1:PIXEL_BITS];
  assign b_cur   = rd_pair[PIXEL_BITS-1:0];
  assign wr_pair = {s1_pix_r, a_cur};

  ipc_clip #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_clip (
    .centre (a1_r),
    .up     (b1_r),
    .left   (a2_r),
    .down   (x1_r),
    .right  (a_cur),
    .nbr_en (s1_nbr_r),
    .result (clip_pix)
  );

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r      <= W_M1_RST;
      h_m1_r      <= H_M1_RST;
      col_in_r    <= '0;
      row_in_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      s1_valid_r  <= 1'b0;
      byp_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      w_m1_r    <= w_m1_nxt;
      h_m1_r    <= h_m1_nxt;
      col_in_r  <= col_in_nxt;
      row_in_r  <= row_in_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (acc_active) begin
        s1_valid_r <= 1'b1;
        byp_hit_r  <= s1_fire && (s1_col_r == col_in_r);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_active) begin
      s1_pix_r   <= s0_pix;
      s1_col_r   <= col_in_r;
      s1_emit_r  <= s0_emit;
      s1_eof_r   <= s0_eof;
      s1_nbr_r   <= s0_nbr;
      byp_data_r <= wr_pair;
    end
    if (s1_fire) begin
      a2_r <= a1_r;
      a1_r <= a_cur;
      b1_r <= b_cur;
      x1_r <= s1_pix_r;
    end
    if (s1_fire && s1_emit_r) begin
      out_pix_r <= clip_pix;
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pix_r;
  assign out_end_of_frame = out_eof_r;

  // ------------------------------------------------------------ assertions
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_in_r <= w_m1_r)
    else $error("input column beyond frame width");

  a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_row_r <= h_m1_r) && (out_col_r <= w_m1_r))
    else $error("output position beyond frame");

  a_emit_lags_input: assert property (@(posedge clk) disable iff (!rst_n)
    acc_active && s0_emit |-> row_in_r != '0)
    else $error("result issued before a full row was taken");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc_active && s0_emit && s0_eof && !cfg_wr_en |=>
      (row_in_r == '0) && (col_in_r == '0) && (out_row_r == '0) && (out_col_r == '0))
    else $error("positions not cleared after last pixel of frame");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_emit_r |=> out_valid_r)
    else $error("emitting item did not reach the output register");

endmodule
